[rtl/prm_pkg.sv]
// Shared types and constants for the pending request matcher.
// Used by the controller, the datapath, the top level and the checker.
package prm_pkg;

  // Input command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_RESP   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_MATCHED   = 3'd2;
  localparam logic [2:0] ST_UNMATCHED = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;
  localparam logic [2:0] ST_IDLE_TICK = 3'd5;

  localparam logic [16:0] AGE_MAX       = 17'h1FFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] fcode;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] req_id;
    logic [15:0] code_out;
    logic        last;
  } out_item_t;

  // What a table scan looks for
  typedef enum logic [1:0] {
    MODE_FREE,
    MODE_MATCH,
    MODE_AGE,
    MODE_SEL
  } scan_mode_t;

  // Result to commit once a scan has finished
  typedef enum logic [2:0] {
    COMMIT_NONE,
    COMMIT_ADD,
    COMMIT_MATCH,
    COMMIT_IDLE_TICK,
    COMMIT_EXPIRE
  } commit_t;

  typedef struct packed {
    logic       scan_go;
    scan_mode_t mode;
    commit_t    commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic exp_none;
    logic exp_more;
  } ctrl_stat_t;

endpackage

[rtl/prm_ctrl.sv]
// Controller for the pending request matcher: sequences table scans and
// result commits. Depends on prm_pkg.
module prm_ctrl
  import prm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] command,
  input  ctrl_stat_t stat,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_RESP,
    S_AGE,
    S_TDEC,
    S_EXP
  } state_t;

  state_t    state_r;
  ctrl_cmd_t cmd_r;

  assign busy = (state_r != S_IDLE);
  assign cmd  = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= '{scan_go: 1'b0, mode: MODE_FREE, commit: COMMIT_NONE};
    end else begin
      // pulses drop by default
      cmd_r.scan_go <= 1'b0;
      cmd_r.commit  <= COMMIT_NONE;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            case (command)
              CMD_ADD: begin
                cmd_r.scan_go <= 1'b1;
                cmd_r.mode    <= MODE_FREE;
                state_r       <= S_ADD;
              end
              CMD_RESP: begin
                cmd_r.scan_go <= 1'b1;
                cmd_r.mode    <= MODE_MATCH;
                state_r       <= S_RESP;
              end
              CMD_TICK: begin
                cmd_r.scan_go <= 1'b1;
                cmd_r.mode    <= MODE_AGE;
                state_r       <= S_AGE;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          if (stat.scan_done) begin
            cmd_r.commit <= COMMIT_ADD;
            state_r      <= S_IDLE;
          end
        end
        S_RESP: begin
          if (stat.scan_done) begin
            cmd_r.commit <= COMMIT_MATCH;
            state_r      <= S_IDLE;
          end
        end
        S_AGE: begin
          if (stat.scan_done) begin
            state_r <= S_TDEC;
          end
        end
        S_TDEC: begin
          if (stat.exp_none) begin
            cmd_r.commit <= COMMIT_IDLE_TICK;
            state_r      <= S_IDLE;
          end else begin
            cmd_r.scan_go <= 1'b1;
            cmd_r.mode    <= MODE_SEL;
            state_r       <= S_EXP;
          end
        end
        S_EXP: begin
          if (stat.scan_done) begin
            cmd_r.commit <= COMMIT_EXPIRE;
            // look for the next smallest id while this one is committed
            if (stat.exp_more) begin
              cmd_r.scan_go <= 1'b1;
              cmd_r.mode    <= MODE_SEL;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/prm_datapath.sv]
// Datapath for the pending request matcher: entry table, scan pipeline,
// best-entry tracking, id counter and result register. Depends on prm_pkg.
module prm_datapath
  import prm_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_accept,
  input  logic [15:0] in_func,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  ctrl_cmd_t   cmd,
  output ctrl_stat_t  stat,
  output logic        out_strobe,
  output out_item_t   out_item
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] code;
    logic [16:0] age;
  } entry_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_r;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] sel_r;
  logic [IDX_W-1:0]       addr_r;
  logic [IDX_W-1:0]       chk_idx_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic                   issuing_r;
  logic                   chk_vld_r;
  logic                   best_found_r;
  logic [31:0]            best_id_r;
  logic [15:0]            best_code_r;
  logic [31:0]            next_id_r;
  logic [15:0]            func_r;
  logic [15:0]            timeout_r;
  scan_mode_t             mode_r;
  logic [CNT_W-1:0]       exp_cnt_r;
  logic                   out_strobe_r;
  out_item_t              out_item_r;

  logic [16:0]      new_age;
  logic             age_exp;
  logic             cand;
  logic             age_wr;
  logic             add_wr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  always_comb begin
    new_age = (rd_r.age == AGE_MAX) ? rd_r.age : rd_r.age + 17'd1;
    age_exp = (new_age > {1'b0, timeout_r});
    case (mode_r)
      MODE_FREE:  cand = !valid_r[chk_idx_r] && !best_found_r;
      MODE_MATCH: cand = valid_r[chk_idx_r] && (rd_r.code == func_r) &&
                         (!best_found_r || (rd_r.id < best_id_r));
      MODE_SEL:   cand = sel_r[chk_idx_r] &&
                         (!best_found_r || (rd_r.id < best_id_r));
      default:    cand = 1'b0;
    endcase
    age_wr = chk_vld_r && (mode_r == MODE_AGE) && valid_r[chk_idx_r];
    add_wr = (cmd.commit == COMMIT_ADD) && best_found_r;
    mem_we = age_wr || add_wr;
    if (add_wr) begin
      mem_waddr = best_idx_r;
      mem_wdata = '{id: next_id_r, code: func_r, age: 17'd0};
    end else begin
      mem_waddr = chk_idx_r;
      mem_wdata = '{id: rd_r.id, code: rd_r.code, age: new_age};
    end
  end

  assign stat.scan_done = chk_vld_r && (chk_idx_r == LAST_IDX);
  assign stat.exp_none  = (exp_cnt_r == '0);
  assign stat.exp_more  = (exp_cnt_r > CNT_ONE);
  assign out_strobe     = out_strobe_r;
  assign out_item       = out_item_r;

  // Table storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issuing_r) begin
      rd_r      <= mem[addr_r];
      chk_idx_r <= addr_r;
    end
    if (in_accept) begin
      func_r <= in_func;
    end
    if (chk_vld_r && cand) begin
      best_idx_r  <= chk_idx_r;
      best_id_r   <= rd_r.id;
      best_code_r <= rd_r.code;
    end
  end

  // Scan sequencing, best-entry flag, expiry bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r    <= 1'b0;
      chk_vld_r    <= 1'b0;
      addr_r       <= '0;
      best_found_r <= 1'b0;
      mode_r       <= MODE_FREE;
      sel_r        <= '0;
      exp_cnt_r    <= '0;
    end else begin
      chk_vld_r <= issuing_r;
      if (cmd.scan_go) begin
        issuing_r    <= 1'b1;
        addr_r       <= '0;
        mode_r       <= cmd.mode;
        best_found_r <= 1'b0;
        if (cmd.mode == MODE_AGE) begin
          exp_cnt_r <= '0;
        end
      end else begin
        if (issuing_r) begin
          if (addr_r == LAST_IDX) begin
            issuing_r <= 1'b0;
          end else begin
            addr_r <= addr_r + IDX_ONE;
          end
        end
        if (chk_vld_r && cand) begin
          best_found_r <= 1'b1;
        end
      end
      if (age_wr && age_exp) begin
        sel_r[chk_idx_r] <= 1'b1;
        exp_cnt_r        <= exp_cnt_r + CNT_ONE;
      end else if (cmd.commit == COMMIT_EXPIRE) begin
        sel_r[best_idx_r] <= 1'b0;
        exp_cnt_r         <= exp_cnt_r - CNT_ONE;
      end
    end
  end

  // Entry valid bits, id counter and timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      next_id_r <= '0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      case (cmd.commit)
        COMMIT_ADD: begin
          if (best_found_r) begin
            valid_r[best_idx_r] <= 1'b1;
            next_id_r           <= next_id_r + 32'd1;
          end
        end
        COMMIT_MATCH: begin
          if (best_found_r) begin
            valid_r[best_idx_r] <= 1'b0;
          end
        end
        COMMIT_EXPIRE: valid_r[best_idx_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Result register: one transfer per commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cmd.commit != COMMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.commit)
      COMMIT_ADD: begin
        if (best_found_r) begin
          out_item_r <= '{status: ST_ADDED, req_id: next_id_r,
                          code_out: func_r, last: 1'b1};
        end else begin
          out_item_r <= '{status: ST_FULL, req_id: 32'd0,
                          code_out: func_r, last: 1'b1};
        end
      end
      COMMIT_MATCH: begin
        if (best_found_r) begin
          out_item_r <= '{status: ST_MATCHED, req_id: best_id_r,
                          code_out: best_code_r, last: 1'b1};
        end else begin
          out_item_r <= '{status: ST_UNMATCHED, req_id: 32'd0,
                          code_out: func_r, last: 1'b1};
        end
      end
      COMMIT_IDLE_TICK: begin
        out_item_r <= '{status: ST_IDLE_TICK, req_id: 32'd0,
                        code_out: 16'd0, last: 1'b1};
      end
      COMMIT_EXPIRE: begin
        out_item_r <= '{status: ST_EXPIRED, req_id: best_id_r,
                        code_out: best_code_r, last: (exp_cnt_r == CNT_ONE)};
      end
      default: out_item_r <= out_item_r;
    endcase
  end

endmodule

[rtl/pending_request_matcher_top.sv]
// Pending request matcher, top level: joins the controller and the datapath.
// Depends on prm_pkg, prm_ctrl and prm_datapath.
//
// Tracks up to TABLE_DEPTH outstanding requests. A command is taken when
// start is high and busy is low; each result is shown for one cycle with
// out_strobe and cannot be held off. An add or a response scans the entry
// table once through its single read port, one entry per cycle, and its
// result strobes in the cycle after the block can take the next command.
// A tick scans the table once to age every entry and then once more per
// expired entry to pick the smallest id still owed; it gives one idle-tick
// result when nothing expires, else one result per expired entry in rising
// id order. The expiry limit is written through cfg_wr_en and cfg_wr_data;
// the user must do so only while idle, as the block does not enforce it.
module pending_request_matcher_top
  import prm_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       in_accept;

  assign in_accept = start && !busy;

  prm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_item.command),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  prm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_func     (in_item.fcode),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_strobe  (out_strobe),
    .out_item    (out_item)
  );

endmodule

[rtl/prm_checker.sv]
// Port-level checks for the pending request matcher, bound to the top level.
// Depends on prm_pkg and pending_request_matcher_top.
module prm_port_checks
  import prm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_strobe,
  input out_item_t out_item
);

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.status <= ST_IDLE_TICK))
    else $error("result status out of range");

  // only expiry runs give more than one result
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status != ST_EXPIRED)) |-> out_item.last)
    else $error("non-expiry result without last");

  // a run that is not finished keeps the block busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |-> busy)
    else $error("idle with expiry results still owed");

  // results without an entry carry id zero
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && ((out_item.status == ST_FULL) ||
                    (out_item.status == ST_UNMATCHED) ||
                    (out_item.status == ST_IDLE_TICK)))
      |-> (out_item.req_id == 32'd0))
    else $error("non-zero id on result without entry");

  // an accepted add, response or tick starts a scan
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.command != CMD_UNUSED)) |=> busy)
    else $error("accepted command did not start work");

endmodule

bind pending_request_matcher_top prm_port_checks u_prm_port_checks (.*);
